// ===== rtl/gfskds_pkg.sv =====
// Shared constants, register indexes and the CORDIC arctangent table for the
// GFSK discriminator and slicer. No dependencies.
package gfskds_pkg;

  // Phase word: pi maps to 32768, so one full turn spans the 16-bit range.
  localparam int unsigned PhaseW   = 16;
  localparam int signed   PhaseMax = 32767;
  localparam int signed   PhaseMin = -32768;

  // Angle accumulator inside the CORDIC, wide enough for a quarter turn plus
  // the sum of every table entry.
  localparam int unsigned ZW       = 18;
  localparam int signed   ZQuarter = 16384;

  // Arctangent table: length and entry width.
  localparam int unsigned AtanLen  = 20;
  localparam int unsigned AtanW    = 14;
  localparam int unsigned AtanIdxW = 5;

  // Configuration register widths.
  localparam int unsigned SpsW     = 7;
  localparam int unsigned SkipW    = 16;
  localparam int unsigned GainW    = 24;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CfgIdxW  = 2;

  // Quality output: 16 bits after a right shift of 16.
  localparam int unsigned QualW    = 16;
  localparam int unsigned QShift   = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSps  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSkip = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGain = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [SpsW-1:0]  SpsReset  = 7'd8;
  localparam logic [SkipW-1:0] SkipReset = 16'd0;
  localparam logic [GainW-1:0] GainReset = 24'd65536;

  // Default parameter values.
  localparam int unsigned DefMaxSps      = 64;
  localparam int unsigned DefSampleBits  = 16;
  localparam int unsigned DefCordicSteps = 16;

  // atan(2^-k) scaled so that pi is 32768.
  function automatic logic [AtanW-1:0] atan_lut(input logic [AtanIdxW-1:0] k);
    logic [AtanW-1:0] a;
    unique case (k)
      5'd0:    a = 14'd8192;
      5'd1:    a = 14'd4836;
      5'd2:    a = 14'd2555;
      5'd3:    a = 14'd1297;
      5'd4:    a = 14'd651;
      5'd5:    a = 14'd326;
      5'd6:    a = 14'd163;
      5'd7:    a = 14'd81;
      5'd8:    a = 14'd41;
      5'd9:    a = 14'd20;
      5'd10:   a = 14'd10;
      5'd11:   a = 14'd5;
      5'd12:   a = 14'd3;
      5'd13:   a = 14'd1;
      5'd14:   a = 14'd1;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/gfskds_cordic.sv =====
// Iterative vectoring CORDIC: one micro-rotation per clock on a single
// shift-add unit. Depends on gfskds_pkg for the arctangent table.
module gfskds_cordic
  import gfskds_pkg::*;
#(
  parameter int unsigned IN_W  = 33,
  parameter int unsigned STEPS = DefCordicSteps
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [IN_W-1:0]   x_i,
  input  logic signed [IN_W-1:0]   y_i,
  output logic                     done_o,
  output logic signed [PhaseW-1:0] phase_o
);

  localparam int unsigned XW   = IN_W + 1;
  localparam int unsigned Iter = (STEPS < AtanLen) ? STEPS : AtanLen;
  localparam int unsigned KW   = $clog2(Iter);

  logic                 busy_q;
  logic                 done_q;
  logic [KW-1:0]        k_q;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;

  logic signed [XW-1:0] x_ext, y_ext, x0, y0, dx, dy, x_nx, y_nx;
  logic signed [ZW-1:0] z0, ang, z_nx;
  logic                 zero_in;

  assign x_ext   = XW'(x_i);
  assign y_ext   = XW'(y_i);
  assign zero_in = (x_i == '0) && (y_i == '0);

  // Quarter-turn pre-rotation brings the vector into the right half plane.
  always_comb begin
    x0 = x_ext;
    y0 = y_ext;
    z0 = '0;
    if (x_ext < 0) begin
      if (y_ext >= 0) begin
        x0 = y_ext;
        y0 = -x_ext;
        z0 = ZW'(ZQuarter);
      end else begin
        x0 = -y_ext;
        y0 = x_ext;
        z0 = -ZW'(ZQuarter);
      end
    end
  end

  // One micro-rotation. Arithmetic shifts round toward minus infinity.
  always_comb begin
    dx  = y_q >>> k_q;
    dy  = x_q >>> k_q;
    ang = signed'(ZW'(atan_lut(AtanIdxW'(k_q))));
    if (y_q >= 0) begin
      x_nx = x_q + dx;
      y_nx = y_q - dy;
      z_nx = z_q + ang;
    end else begin
      x_nx = x_q - dx;
      y_nx = y_q + dy;
      z_nx = z_q - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          if (zero_in) begin
            done_q <= 1'b1;
          end else begin
            busy_q <= 1'b1;
            k_q    <= '0;
          end
        end
      end else begin
        if (k_q == KW'(Iter - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (start_i) begin
        x_q <= x0;
        y_q <= y0;
        z_q <= zero_in ? '0 : z0;
      end
    end else begin
      x_q <= x_nx;
      y_q <= y_nx;
      z_q <= z_nx;
    end
  end

  // Saturate the angle so that a full half turn reads as the largest phase.
  always_comb begin
    if (z_q > ZW'(PhaseMax)) begin
      phase_o = PhaseW'(PhaseMax);
    end else if (z_q < ZW'(PhaseMin)) begin
      phase_o = PhaseW'(PhaseMin);
    end else begin
      phase_o = PhaseW'(z_q);
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/gfsk_discriminator_slicer.sv =====
// Top level of the GFSK quadrature discriminator and symbol slicer.
// Depends on gfskds_pkg and gfskds_cordic.

// Each input transfer carries one complex sample. The block multiplies it by
// the conjugate of the previous sample on one shared 16x16 multiplier (four
// products in turn), takes the phase of that product with an iterative
// CORDIC that does one micro-rotation per clock, and sums the phases over
// samples_per_symbol samples, after start_skip samples of each frame have
// been discarded. At the end of every symbol one result transfer carries the
// sliced bit and a saturating quality figure. After the CORDIC, the last
// sample of a symbol also passes through the magnitude, quality multiply and
// output register load steps. A sample whose conjugate product is zero, such
// as the first sample of a frame, bypasses the micro-rotations. A skipped
// sample, and any sample while samples_per_symbol is zero, is taken without
// leaving the idle state. The CORDIC loop sets the rate.
// The result sits in an output register; the block takes further samples
// while it waits, and only stalls once a second result is ready before the
// first has been taken. The configuration port is always ready and must only
// be written while the block is idle; unused register indexes are ignored.
module gfsk_discriminator_slicer
  import gfskds_pkg::*;
#(
  parameter int unsigned MAX_SPS      = DefMaxSps,
  parameter int unsigned SAMPLE_BITS  = DefSampleBits,
  parameter int unsigned CORDIC_STEPS = DefCordicSteps
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Sample channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  sample_i_i,
  input  logic signed [15:0]  sample_q_i,
  input  logic                frame_start_i,
  // Symbol channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                bit_res_o,
  output logic [QualW-1:0]    quality_o
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned ProdW  = 2 * SB;
  localparam int unsigned ReW    = ProdW + 1;
  localparam int unsigned SumW   = $clog2(MAX_SPS) + PhaseW;
  localparam int unsigned CntW   = $clog2(MAX_SPS + 1);
  localparam int unsigned CmpW   = ((CntW > SpsW) ? CntW : SpsW) + 1;
  localparam int unsigned QProdW = SumW + GainW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CORDIC,
    S_ABS,
    S_QMUL,
    S_EMIT
  } state_e;

  // Order of the four partial products of the conjugate multiply.
  typedef enum logic [2:0] {
    M_II,
    M_QQ,
    M_QI,
    M_IQ,
    M_LAST
  } mul_step_e;

  state_e                state_q;
  mul_step_e             mstep_q;

  // Configuration.
  logic [SpsW-1:0]       sps_q;
  logic [SkipW-1:0]      skip_cfg_q;
  logic [GainW-1:0]      gain_q;

  // Running state.
  logic signed [SB-1:0]  prev_i_q, prev_q_q;
  logic [SkipW-1:0]      skip_left_q;
  logic [CntW-1:0]       cnt_q;
  logic signed [SumW-1:0] sum_q;

  // Per-sample working registers.
  logic signed [SB-1:0]  cur_i_q, cur_q_q, op_pi_q, op_pq_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ReW-1:0] re_q, im_q;
  logic                  start_q;
  logic signed [SumW-1:0] sum_fin_q;
  logic [SumW-1:0]       mag_q;
  logic [QProdW-1:0]     qprod_q;

  // Output register.
  logic                  out_valid_q;
  logic                  bit_q;
  logic [QualW-1:0]      quality_q;

  // Combinational helpers.
  logic signed [SB-1:0]  smp_i, smp_q, mul_a, mul_b;
  logic signed [ProdW-1:0] prod_d;
  logic [SkipW-1:0]      skip_now;
  logic signed [PhaseW-1:0] cord_phase;
  logic                  cord_done;
  logic signed [SumW-1:0] sum_d;
  logic [CmpW-1:0]       sps_ext, max_ext, sps_eff, cnt_inc;
  logic                  sym_end;
  logic                  q_sat;
  logic                  in_fire;
  logic                  emit_go;

  assign smp_i   = sample_i_i[SB-1:0];
  assign smp_q   = sample_q_i[SB-1:0];
  assign in_fire = in_valid_i && in_ready_o;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  // A frame start loads the skip counter before this sample is judged.
  assign skip_now = frame_start_i ? skip_cfg_q : skip_left_q;

  // Shared multiplier operand selection.
  always_comb begin
    unique case (mstep_q)
      M_II: begin
        mul_a = cur_i_q;
        mul_b = op_pi_q;
      end
      M_QQ: begin
        mul_a = cur_q_q;
        mul_b = op_pq_q;
      end
      M_QI: begin
        mul_a = cur_q_q;
        mul_b = op_pi_q;
      end
      M_IQ: begin
        mul_a = cur_i_q;
        mul_b = op_pq_q;
      end
      default: begin
        mul_a = cur_i_q;
        mul_b = op_pi_q;
      end
    endcase
  end

  assign prod_d = ProdW'(mul_a) * ProdW'(mul_b);

  gfskds_cordic #(
    .IN_W  (ReW),
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .x_i     (re_q),
    .y_i     (im_q),
    .done_o  (cord_done),
    .phase_o (cord_phase)
  );

  // Symbol accounting. A symbol closes once the count reaches or passes the
  // setting, clamped to MAX_SPS.
  assign sum_d   = sum_q + SumW'(cord_phase);
  assign sps_ext = CmpW'(sps_q);
  assign max_ext = CmpW'(MAX_SPS);
  assign sps_eff = (sps_ext > max_ext) ? max_ext : sps_ext;
  assign cnt_inc = CmpW'(cnt_q) + 1'b1;
  assign sym_end = (cnt_inc >= sps_eff);

  assign q_sat = |qprod_q[QProdW-1:QShift+QualW];

  // A finished result loads the output register once it is free or is being
  // taken at this edge.
  assign emit_go = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mstep_q     <= M_II;
      sps_q       <= SpsReset;
      skip_cfg_q  <= SkipReset;
      gain_q      <= GainReset;
      prev_i_q    <= '0;
      prev_q_q    <= '0;
      skip_left_q <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      cur_i_q     <= '0;
      cur_q_q     <= '0;
      op_pi_q     <= '0;
      op_pq_q     <= '0;
      prod_q      <= '0;
      re_q        <= '0;
      im_q        <= '0;
      start_q     <= 1'b0;
      sum_fin_q   <= '0;
      mag_q       <= '0;
      qprod_q     <= '0;
      out_valid_q <= 1'b0;
      bit_q       <= 1'b0;
      quality_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegSps:  sps_q      <= cfg_data_i[SpsW-1:0];
          RegSkip: skip_cfg_q <= cfg_data_i[SkipW-1:0];
          RegGain: gain_q     <= cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end

      // The output register empties on a result transfer unless a new result
      // replaces it at the same edge.
      if (out_valid_q && out_ready_i && !emit_go) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cur_i_q  <= smp_i;
            cur_q_q  <= smp_q;
            // The previous sample counts as zero at a frame start.
            op_pi_q  <= frame_start_i ? '0 : prev_i_q;
            op_pq_q  <= frame_start_i ? '0 : prev_q_q;
            prev_i_q <= smp_i;
            prev_q_q <= smp_q;
            if (frame_start_i) begin
              cnt_q <= '0;
              sum_q <= '0;
            end
            if (skip_now != '0) begin
              skip_left_q <= skip_now - 1'b1;
            end else begin
              skip_left_q <= skip_now;
              if (sps_q != '0) begin
                mstep_q <= M_II;
                state_q <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          // One product per cycle; each is added in the cycle after it.
          prod_q <= prod_d;
          unique case (mstep_q)
            M_II: mstep_q <= M_QQ;
            M_QQ: begin
              re_q    <= ReW'(prod_q);
              mstep_q <= M_QI;
            end
            M_QI: begin
              re_q    <= re_q + ReW'(prod_q);
              mstep_q <= M_IQ;
            end
            M_IQ: begin
              im_q    <= ReW'(prod_q);
              mstep_q <= M_LAST;
            end
            default: begin
              im_q    <= im_q - ReW'(prod_q);
              start_q <= 1'b1;
              state_q <= S_CORDIC;
            end
          endcase
        end
        S_CORDIC: begin
          start_q <= 1'b0;
          if (cord_done) begin
            if (sym_end) begin
              sum_fin_q <= sum_d;
              sum_q     <= '0;
              cnt_q     <= '0;
              state_q   <= S_ABS;
            end else begin
              sum_q   <= sum_d;
              cnt_q   <= cnt_q + 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        S_ABS: begin
          mag_q   <= (sum_fin_q < 0) ? SumW'(-sum_fin_q) : SumW'(sum_fin_q);
          state_q <= S_QMUL;
        end
        S_QMUL: begin
          qprod_q <= QProdW'(mag_q) * QProdW'(gain_q);
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          // Hold until the output register is free.
          if (emit_go) begin
            out_valid_q <= 1'b1;
            bit_q       <= (sum_fin_q > 0);
            quality_q   <= q_sat ? '1 : qprod_q[QShift+QualW-1:QShift];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign bit_res_o   = bit_q;
  assign quality_o   = quality_q;

`ifndef SYNTHESIS
  // A result only appears after the quality path has run.
  a_emit_from_quality: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result raised outside the emit step");

  // The CORDIC only finishes while the sequencer waits for it.
  a_cordic_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> (state_q == S_CORDIC))
    else $error("CORDIC finished while the sequencer was not waiting");

  // Between samples the symbol count stays below MAX_SPS.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (CmpW'(cnt_q) < max_ext))
    else $error("symbol count reached its limit without closing the symbol");
`endif

endmodule
